// ===== src/trpm_pkg.sv =====
// ----------------------------------------------------------------------------
// trpm_pkg
// Shared widths, register indexes and trigger mode codes of the RMS peak meter.
// ----------------------------------------------------------------------------
package trpm_pkg;

	localparam int SUM_W   = 64;
	localparam int CNT_W   = 32;
	localparam int CH_W    = 4;
	localparam int SEQ_W   = 16;
	localparam int THR_W   = 24;
	localparam int ROOT_W  = 32;
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_TRIG_ENABLE  = 3'd0;
	localparam reg_idx_t REG_TRIG_CHANNEL = 3'd1;
	localparam reg_idx_t REG_TRIG_MODE    = 3'd2;
	localparam reg_idx_t REG_TRIG_RISING  = 3'd3;
	localparam reg_idx_t REG_RAPID_THR    = 3'd4;

	typedef logic [1:0] trig_mode_t;
	localparam trig_mode_t MODE_ZERO_CROSS = 2'd0;
	localparam trig_mode_t MODE_RAPID_EDGE = 2'd1;
	localparam trig_mode_t MODE_TURN       = 2'd2;

	localparam logic [THR_W-1:0] THR_RESET = 24'd1000;

endpackage

// ===== src/trpm_ram.sv =====
// ----------------------------------------------------------------------------
// trpm_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module trpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/trpm_rms_unit.sv =====
// ----------------------------------------------------------------------------
// trpm_rms_unit
// Bit-serial mean and square root: floor(sqrt(sum / count)), count nonzero.
// ----------------------------------------------------------------------------
module trpm_rms_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [trpm_pkg::SUM_W-1:0] sum,
	input  logic [trpm_pkg::CNT_W-1:0] count,
	output logic                       done,
	output logic [trpm_pkg::ROOT_W-1:0] root
);
	import trpm_pkg::*;

	typedef enum logic [1:0] {U_IDLE, U_DIV, U_SQRT} ustate_t;

	ustate_t             st_q;
	logic [5:0]          step_q;
	logic [SUM_W-1:0]    dq_q;
	logic [CNT_W-1:0]    drem_q;
	logic [CNT_W-1:0]    div_q;
	logic [ROOT_W+2:0]   srem_q;
	logic [ROOT_W-1:0]   root_q;
	logic                done_q;

	logic [CNT_W:0]      dtrial;
	logic                dge;
	logic [ROOT_W+2:0]   strial;
	logic [ROOT_W+2:0]   sshift;
	logic                sge;

	always_comb begin
		dtrial = {drem_q, dq_q[SUM_W-1]};
		dge    = (dtrial >= {1'b0, div_q});
		sshift = {srem_q[ROOT_W:0], dq_q[SUM_W-1:SUM_W-2]};
		strial = {1'b0, root_q, 2'b01};
		sge    = (sshift >= strial);
	end

	// The quotient is built in dq_q and then consumed two bits at a time by
	// the digit-by-digit root.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= U_IDLE;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				U_IDLE: begin
					if (start) begin
						dq_q   <= sum;
						div_q  <= count;
						drem_q <= '0;
						step_q <= '0;
						st_q   <= U_DIV;
					end
				end
				U_DIV: begin
					drem_q <= dge ? CNT_W'(dtrial - {1'b0, div_q}) : dtrial[CNT_W-1:0];
					dq_q   <= {dq_q[SUM_W-2:0], dge};
					step_q <= step_q + 6'd1;
					if (step_q == 6'd63) begin
						srem_q <= '0;
						root_q <= '0;
						st_q   <= U_SQRT;
					end
				end
				U_SQRT: begin
					srem_q <= sge ? (sshift - strial) : sshift;
					root_q <= {root_q[ROOT_W-2:0], sge};
					dq_q   <= {dq_q[SUM_W-3:0], 2'b00};
					step_q <= step_q + 6'd1;
					if (step_q == 6'd31) begin
						done_q <= 1'b1;
						st_q   <= U_IDLE;
					end
				end
				default: st_q <= U_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== src/triggered_rms_peak_meter.sv =====
// ----------------------------------------------------------------------------
// triggered_rms_peak_meter
// Per-channel RMS and peak-to-peak meter with a configurable trigger.
// ----------------------------------------------------------------------------
// An ordinary sample goes from transfer to the next ready through one RAM
// read, the squaring multiplier and one read-modify-write of the channel's
// entry, plus a check of the end-of-reading mark. A triggered end of reading
// then walks the channels one per cycle while they are unseen; each seen channel
// with samples also waits for the bit-serial divider (64 steps) and square root
// (32 steps) of the RMS unit, and waits while the output register is still full.
// The per-channel sums, counts and extremes live in one RAM; seen flags reset
// to clear and an unseen entry reads as zero, so no clearing pass is needed.
module triggered_rms_peak_meter #(
	parameter int NUM_CHANNELS = 16,
	parameter int SAMPLE_BITS  = 24
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [trpm_pkg::PADDR_W-1:0]          paddr,
	input  logic [trpm_pkg::PDATA_W-1:0]          pwdata,
	output logic [trpm_pkg::PDATA_W-1:0]          prdata,
	output logic                                  pready,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// channel, sample (from bit 0 up), zero padded
	input  logic [((4+SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,
	input  logic                                  s_tlast,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// out_channel, rms, peak_to_peak, sequence_number, empty_window (bit 0 up)
	output logic [((21+2*SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
	output logic                                  m_tlast
);
	import trpm_pkg::*;

	localparam int AW     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int CW     = (AW > CH_W) ? AW : CH_W;
	localparam int SB     = SAMPLE_BITS;
	localparam int WORD_W = SUM_W + CNT_W + 2 * SB;
	localparam int OUT_W  = ((21 + 2 * SB + 7) / 8) * 8;
	localparam int TW     = 34;

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_ACC, S_EOR, S_SCAN, S_CALC, S_DIV, S_EMIT
	} state_t;

	// Configuration registers
	logic                trig_en_q;
	logic [CH_W-1:0]     trig_ch_q;
	trig_mode_t          trig_mode_q;
	logic                trig_rise_q;
	logic [THR_W-1:0]    thr_q;
	logic                cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_en_q   <= 1'b0;
			trig_ch_q   <= '0;
			trig_mode_q <= MODE_TURN;
			trig_rise_q <= 1'b0;
			thr_q       <= THR_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_TRIG_ENABLE:  trig_en_q   <= pwdata[0];
				REG_TRIG_CHANNEL: trig_ch_q   <= pwdata[CH_W-1:0];
				REG_TRIG_MODE:    trig_mode_q <= pwdata[1:0];
				REG_TRIG_RISING:  trig_rise_q <= pwdata[0];
				REG_RAPID_THR:    thr_q       <= pwdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_TRIG_ENABLE:  prdata = PDATA_W'(trig_en_q);
			REG_TRIG_CHANNEL: prdata = PDATA_W'(trig_ch_q);
			REG_TRIG_MODE:    prdata = PDATA_W'(trig_mode_q);
			REG_TRIG_RISING:  prdata = PDATA_W'(trig_rise_q);
			REG_RAPID_THR:    prdata = PDATA_W'(thr_q);
			default:          prdata = '0;
		endcase
	end

	// Datapath state
	state_t                  st_q;
	logic [CH_W-1:0]         ch_q;
	logic signed [SB-1:0]    samp_q;
	logic                    eor_q;
	logic [2*SB-1:0]         sq_s1;
	logic [NUM_CHANNELS-1:0] seen_q;
	logic                    pending_q;
	logic                    prev_neg_q;
	logic                    prev_dec_q;
	logic signed [SB-1:0]    prev_val_q;
	logic [SEQ_W-1:0]        seq_q;
	logic [AW-1:0]           idx_q;
	logic                    empty_q;
	logic                    m_tvalid_q;
	logic [OUT_W-1:0]        m_tdata_q;
	logic                    m_tlast_q;

	// Input unpacking
	logic [CH_W-1:0]         in_ch;
	logic [CW-1:0]           in_ch_ext;
	logic                    in_range;
	logic [CW-1:0]           ch_ext;
	logic [AW-1:0]           ch_addr;

	assign in_ch     = s_tdata[CH_W-1:0];
	assign in_ch_ext = CW'(in_ch);
	assign in_range  = (32'(in_ch) < 32'(NUM_CHANNELS));
	assign ch_ext    = CW'(ch_q);
	assign ch_addr   = ch_ext[AW-1:0];
	assign s_tready  = (st_q == S_IDLE);

	// RAM
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [WORD_W-1:0] ram_rdata;

	trpm_ram #(
		.WIDTH (WORD_W),
		.DEPTH (NUM_CHANNELS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	logic [SUM_W-1:0]     rd_sum;
	logic [CNT_W-1:0]     rd_cnt;
	logic signed [SB-1:0] rd_max;
	logic signed [SB-1:0] rd_min;

	assign rd_sum = ram_rdata[WORD_W-1 -: SUM_W];
	assign rd_cnt = ram_rdata[2*SB +: CNT_W];
	assign rd_max = ram_rdata[SB +: SB];
	assign rd_min = ram_rdata[SB-1:0];

	// Accumulation: an entry never written reads as an empty window.
	logic                 acc_seen;
	logic [SUM_W-1:0]     cur_sum;
	logic [CNT_W-1:0]     cur_cnt;
	logic [SUM_W:0]       sum_add;
	logic [SUM_W-1:0]     new_sum;
	logic [CNT_W-1:0]     new_cnt;
	logic signed [SB-1:0] new_max;
	logic signed [SB-1:0] new_min;
	logic [SB-1:0]        mag;

	always_comb begin
		acc_seen = seen_q[ch_addr];
		cur_sum  = acc_seen ? rd_sum : '0;
		cur_cnt  = acc_seen ? rd_cnt : '0;
		sum_add  = {1'b0, cur_sum} + (SUM_W + 1)'(sq_s1);
		new_sum  = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
		new_cnt  = (cur_cnt == {CNT_W{1'b1}}) ? cur_cnt : cur_cnt + CNT_W'(1);
		if (cur_cnt == '0) begin
			new_max = samp_q;
			new_min = samp_q;
		end else begin
			new_max = (samp_q > rd_max) ? samp_q : rd_max;
			new_min = (samp_q < rd_min) ? samp_q : rd_min;
		end
		mag = samp_q[SB-1] ? SB'(-samp_q) : SB'(samp_q);
	end

	// Trigger test on the latched sample
	logic signed [TW-1:0] tv;
	logic signed [TW-1:0] tp;
	logic signed [TW-1:0] tthr;
	logic                 fire;
	logic                 t_lt;
	logic                 t_is_trig;

	always_comb begin
		tv        = TW'(samp_q);
		tp        = TW'(prev_val_q);
		tthr      = TW'(thr_q);
		t_lt      = (samp_q < prev_val_q);
		t_is_trig = trig_en_q && (ch_q == trig_ch_q);
		case (trig_mode_q)
			MODE_ZERO_CROSS: fire = trig_rise_q ? (prev_neg_q && !samp_q[SB-1])
			                                    : (!prev_neg_q && (samp_q <= 0));
			MODE_RAPID_EDGE: fire = trig_rise_q ? ((tv - tp) > tthr) : ((tp - tv) > tthr);
			default:         fire = trig_rise_q ? (!prev_dec_q && t_lt)
			                                    : (prev_dec_q && (samp_q > prev_val_q));
		endcase
	end

	// Burst support
	logic [NUM_CHANNELS-1:0] above;
	logic                    later_seen;
	logic [CW-1:0]           idx_ext;
	logic                    out_free;
	logic                    calc_start;
	logic                    calc_done;
	logic [ROOT_W-1:0]       calc_root;
	logic [SB-1:0]           peak;

	always_comb begin
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			above[i] = (i > int'(idx_q));
		end
		later_seen = |(seen_q & above);
		idx_ext    = CW'(idx_q);
		out_free   = !m_tvalid_q || m_tready;
		calc_start = (st_q == S_CALC) && (rd_cnt != '0);
		peak       = SB'(rd_max - rd_min);
	end

	trpm_rms_unit u_rms (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (calc_start),
		.sum    (rd_sum),
		.count  (rd_cnt),
		.done   (calc_done),
		.root   (calc_root)
	);

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = idx_q;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = {{(SUM_W + CNT_W){1'b0}}, rd_max, rd_min};
		case (st_q)
			S_IDLE: begin
				ram_re    = s_tvalid && in_range;
				ram_raddr = in_ch_ext[AW-1:0];
			end
			S_SCAN: ram_re = seen_q[idx_q];
			S_ACC: begin
				ram_we    = 1'b1;
				ram_waddr = ch_addr;
				ram_wdata = {new_sum, new_cnt, new_max, new_min};
			end
			S_EMIT: ram_we = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_IDLE;
			seen_q     <= '0;
			pending_q  <= 1'b0;
			prev_neg_q <= 1'b0;
			prev_dec_q <= 1'b0;
			prev_val_q <= '0;
			seq_q      <= '0;
			idx_q      <= '0;
			empty_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tlast_q  <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (s_tvalid) begin
						ch_q   <= in_ch;
						samp_q <= s_tdata[CH_W +: SB];
						eor_q  <= s_tlast;
						st_q   <= in_range ? S_RD : S_EOR;
					end
				end
				S_RD: begin
					sq_s1 <= mag * mag;
					st_q  <= S_ACC;
				end
				S_ACC: begin
					seen_q[ch_addr] <= 1'b1;
					if (t_is_trig) begin
						if (fire) begin
							pending_q <= 1'b1;
						end
						if (trig_mode_q == MODE_ZERO_CROSS) begin
							prev_neg_q <= samp_q[SB-1];
						end else begin
							prev_val_q <= samp_q;
							if (trig_mode_q != MODE_RAPID_EDGE) begin
								prev_dec_q <= t_lt;
							end
						end
					end
					st_q <= S_EOR;
				end
				S_EOR: begin
					idx_q <= '0;
					if (eor_q) begin
						pending_q <= 1'b0;
						st_q      <= pending_q ? S_SCAN : S_IDLE;
					end else begin
						st_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (seen_q[idx_q]) begin
						st_q <= S_CALC;
					end else if (idx_q == AW'(NUM_CHANNELS - 1)) begin
						st_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				S_CALC: begin
					empty_q <= (rd_cnt == '0);
					st_q    <= (rd_cnt == '0) ? S_EMIT : S_DIV;
				end
				S_DIV: begin
					if (calc_done) begin
						st_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tlast_q  <= !later_seen;
						m_tdata_q  <= OUT_W'({
							empty_q,
							seq_q,
							empty_q ? {SB{1'b0}} : peak,
							empty_q ? {SB{1'b0}} : calc_root[SB-1:0],
							idx_ext[CH_W-1:0]
						});
						seq_q <= seq_q + SEQ_W'(1);
						if (!later_seen) begin
							st_q <= S_IDLE;
						end else begin
							idx_q <= idx_q + AW'(1);
							st_q  <= S_SCAN;
						end
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule
